[hdl/ssg_pkg.sv]
package ssg_pkg;

	// defaults for the top-level parameters
	localparam int MAX_SUB_DEF   = 64;
	localparam int FRAC_BITS_DEF = 16;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_AVG = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_TOL = 3'd5;

	// arithmetic unit widths (sized for the largest subsegment count)
	localparam int MUL_W  = 38;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SQ_W   = 67;
	localparam int DIV_W  = 34;
	localparam int REM_W  = 31;
	localparam int STEP_W = 6;

	// datapath operations
	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_SQX   = 4'd1;
	localparam logic [3:0] OP_SQY   = 4'd2;
	localparam logic [3:0] OP_SRCH  = 4'd3;
	localparam logic [3:0] OP_DIVX  = 4'd4;
	localparam logic [3:0] OP_DIVY  = 4'd5;
	localparam logic [3:0] OP_CELLX = 4'd6;
	localparam logic [3:0] OP_FRACX = 4'd7;
	localparam logic [3:0] OP_CELLY = 4'd8;
	localparam logic [3:0] OP_FRACY = 4'd9;

	typedef struct packed {
		logic        func;
		logic [31:0] target_x;
		logic [31:0] target_y;
	} in_word_t;

	typedef struct packed {
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [15:0] cell_col;
		logic [15:0] cell_row;
		logic [15:0] frac_x;
		logic [15:0] frac_y;
		logic        saturated;
		logic        last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [3:0] op;
		logic       go;
		logic       fin;
		logic       load;
		logic       step;
		logic       emit;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic div_busy;
		logic mul_done;
		logic div_done;
		logic srch_end;
		logic n_zero;
		logic last;
		logic clamp_x;
		logic clamp_y;
		logic out_full;
	} sts_t;

	// a pitch register holding zero acts as one
	function automatic logic [REM_W-1:0] pitch_of(input logic [REM_W-1:0] r);
		pitch_of = (r == '0) ? REM_W'(1) : r;
	endfunction

endpackage

[hdl/ssg_mul.sv]
module ssg_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ssg_pkg::MUL_W-1:0] a,
	input  logic [ssg_pkg::MUL_W-1:0] b,
	output logic                     busy,
	output logic                     done,
	output logic [ssg_pkg::PROD_W-1:0] prod
);
	import ssg_pkg::*;

	logic [MUL_W:0]    hi_q;
	logic [MUL_W-1:0]  lo_q;
	logic [MUL_W-1:0]  a_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_W:0]    sum;

	// shift-add, one multiplier bit a cycle
	assign sum = hi_q + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(MUL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= {1'b0, sum[MUL_W:1]};
			lo_q <= {sum[0], lo_q[MUL_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = {hi_q[MUL_W-1:0], lo_q};
endmodule

[hdl/ssg_div.sv]
module ssg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ssg_pkg::REM_W-1:0]  rem_init,
	input  logic [ssg_pkg::DIV_W-1:0]  dividend,
	input  logic [ssg_pkg::REM_W-1:0]  divisor,
	input  logic [ssg_pkg::STEP_W-1:0] steps,
	output logic                      busy,
	output logic                      done,
	output logic [ssg_pkg::DIV_W-1:0]  quot,
	output logic [ssg_pkg::REM_W-1:0]  rem
);
	import ssg_pkg::*;

	logic [REM_W-1:0]  r_q;
	logic [DIV_W-1:0]  d_q;
	logic [REM_W-1:0]  dv_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W:0]    trial;
	logic [REM_W:0]    diff;
	logic              qbit;

	// restoring long division, one quotient bit a cycle
	assign trial = {r_q, d_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dv_q};
	assign qbit  = (trial >= {1'b0, dv_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= rem_init;
			d_q  <= dividend;
			dv_q <= divisor;
		end else if (busy_q) begin
			r_q <= qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
			d_q <= {d_q[DIV_W-2:0], qbit};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = d_q;
	assign rem  = r_q;
endmodule

[hdl/ssg_dp.sv]
module ssg_dp #(
	parameter int MAX_SUBSEGMENTS = ssg_pkg::MAX_SUB_DEF,
	parameter int FRAC_BITS       = ssg_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ssg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssg_pkg::CFG_W-1:0]     cfg_data,
	input  ssg_pkg::in_word_t             in_data,
	input  ssg_pkg::cmd_t                 cmd,
	output ssg_pkg::sts_t                 sts,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ssg_pkg::out_word_t            out_data
);
	import ssg_pkg::*;

	localparam int N_W = $clog2(MAX_SUBSEGMENTS + 2);
	localparam logic [N_W-1:0] N_MAX  = N_W'(MAX_SUBSEGMENTS);
	localparam logic [N_W-1:0] N_NONE = N_W'(MAX_SUBSEGMENTS + 1);

	// configuration registers
	logic [31:0]      gsx_q, gsy_q;
	logic [REM_W-1:0] ptx_cfg_q, pty_cfg_q, pavg_q, tol_q;

	// item state
	logic [31:0]        prev_x_q, prev_y_q, tgt_x_q, tgt_y_q;
	logic signed [32:0] dx_q, dy_q;
	logic [REM_W-1:0]   pitch_q;
	logic [SQ_W-1:0]    dsq_q;
	logic [N_W-1:0]     lo_q, hi_q, i_q, rdx_q, rdy_q, rx_q, ry_q;
	logic [31:0]        qdx_q, qdy_q, pt_x_q, pt_y_q;
	logic [15:0]        cx_q, cy_q, fx_q, fy_q;
	logic               clx_q, cly_q;
	logic [REM_W-1:0]   rloc_q;
	logic               out_valid_q;
	out_word_t          out_q;

	// unit wiring
	logic                mul_start, mul_busy, mul_done;
	logic [MUL_W-1:0]    mul_a;
	logic [PROD_W-1:0]   prod;
	logic                div_start, div_busy, div_done;
	logic [REM_W-1:0]    div_rinit, div_dvs, div_rem;
	logic [DIV_W-1:0]    div_dvd, div_quot;
	logic [STEP_W-1:0]   div_steps;

	// derived values
	logic [32:0]        adx, ady;
	logic [REM_W-1:0]   px_eff, py_eff, sel_pitch;
	logic [N_W:0]       mid_sum;
	logic [N_W-1:0]     mid, n_val;
	logic [N_W+REM_W-1:0] kp;
	logic               sat;
	logic signed [32:0] offx, offy, off_cur;
	logic [32:0]        aoff_x, aoff_y;
	logic               div_neg;
	logic               ra_nz;
	logic [35:0]        cmag;
	logic signed [35:0] cval;
	logic [REM_W-1:0]   cur_pitch;
	logic [N_W-1:0]     rd_adj;
	logic [31:0]        qd_adj;
	logic [N_W:0]       rsx, rsy;
	logic               cyx, cyy;
	logic [15:0]        frac16;

	assign adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
	assign ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
	assign px_eff = pitch_of(ptx_cfg_q);
	assign py_eff = pitch_of(pty_cfg_q);

	// pitch choice by axis alignment
	always_comb begin
		if (adx <= {2'b0, tol_q})
			sel_pitch = py_eff;
		else if (ady <= {2'b0, tol_q})
			sel_pitch = px_eff;
		else
			sel_pitch = pitch_of(pavg_q);
	end

	// binary search over the subsegment count
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[N_W:1];
	assign kp      = mid * pitch_q;
	assign sat     = (lo_q == N_NONE);
	assign n_val   = sat ? N_MAX : lo_q;

	// grid offsets of the current point
	assign offx   = $signed({pt_x_q[31], pt_x_q}) - $signed({gsx_q[31], gsx_q});
	assign offy   = $signed({pt_y_q[31], pt_y_q}) - $signed({gsy_q[31], gsy_q});
	assign aoff_x = offx[32] ? 33'(-offx) : 33'(offx);
	assign aoff_y = offy[32] ? 33'(-offy) : 33'(offy);

	// operand selection for the units
	always_comb begin
		mul_start = cmd.go && (cmd.op == OP_SQX || cmd.op == OP_SQY || cmd.op == OP_SRCH);
		div_start = 1'b0;
		div_rinit = '0;
		div_dvd   = '0;
		div_dvs   = px_eff;
		div_steps = STEP_W'(DIV_W);
		case (cmd.op)
			OP_SQX:  mul_a = MUL_W'(adx);
			OP_SQY:  mul_a = MUL_W'(ady);
			default: mul_a = MUL_W'(kp);
		endcase
		case (cmd.op)
			OP_DIVX: begin
				div_start = cmd.go;
				div_dvd   = DIV_W'(adx);
				div_dvs   = REM_W'(n_val);
			end
			OP_DIVY: begin
				div_start = cmd.go;
				div_dvd   = DIV_W'(ady);
				div_dvs   = REM_W'(n_val);
			end
			OP_CELLX: begin
				div_start = cmd.go;
				div_dvd   = DIV_W'(aoff_x);
			end
			OP_FRACX: begin
				div_start = cmd.go;
				div_rinit = rloc_q;
				div_steps = STEP_W'(FRAC_BITS);
			end
			OP_CELLY: begin
				div_start = cmd.go;
				div_dvd   = DIV_W'(aoff_y);
				div_dvs   = py_eff;
			end
			OP_FRACY: begin
				div_start = cmd.go;
				div_rinit = rloc_q;
				div_dvs   = py_eff;
				div_steps = STEP_W'(FRAC_BITS);
			end
			default: ;
		endcase
	end

	ssg_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_a),
		.busy  (mul_busy),
		.done  (mul_done),
		.prod  (prod)
	);

	ssg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.rem_init(div_rinit),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.steps   (div_steps),
		.busy    (div_busy),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	// floor correction of a sign-magnitude quotient
	always_comb begin
		case (cmd.op)
			OP_DIVX:  div_neg = dx_q[32];
			OP_DIVY:  div_neg = dy_q[32];
			OP_CELLX: div_neg = offx[32];
			default:  div_neg = offy[32];
		endcase
		cur_pitch = (cmd.op == OP_CELLY) ? py_eff : px_eff;
		ra_nz  = (div_rem != '0);
		cmag   = {2'b0, div_quot} + 36'(div_neg && ra_nz);
		cval   = div_neg ? -$signed(cmag) : $signed(cmag);
		qd_adj = cval[31:0];
		rd_adj = (div_neg && ra_nz) ? n_val - div_rem[N_W-1:0] : div_rem[N_W-1:0];
	end

	// remainder carry of the running quotients
	assign rsx = {1'b0, rx_q} + {1'b0, rdx_q};
	assign rsy = {1'b0, ry_q} + {1'b0, rdy_q};
	assign cyx = (rsx >= {1'b0, n_val});
	assign cyy = (rsy >= {1'b0, n_val});

	// fraction aligned to 16 bits
	generate
		if (FRAC_BITS >= 16) begin : g_frac_trunc
			assign frac16 = div_quot[FRAC_BITS-1 -: 16];
		end else begin : g_frac_fill
			assign frac16 = {div_quot[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
		end
	endgenerate

	// configuration and last point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gsx_q     <= '0;
			gsy_q     <= '0;
			ptx_cfg_q <= REM_W'(65536);
			pty_cfg_q <= REM_W'(65536);
			pavg_q    <= REM_W'(65536);
			tol_q     <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_X:    gsx_q     <= cfg_data;
					REG_GRID_Y:    gsy_q     <= cfg_data;
					REG_PITCH_X:   ptx_cfg_q <= cfg_data[REM_W-1:0];
					REG_PITCH_Y:   pty_cfg_q <= cfg_data[REM_W-1:0];
					REG_PITCH_AVG: pavg_q    <= cfg_data[REM_W-1:0];
					REG_ALIGN_TOL: tol_q     <= cfg_data[REM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && !in_data.func) begin
				prev_x_q <= in_data.target_x;
				prev_y_q <= in_data.target_y;
			end else if (cmd.finish) begin
				prev_x_q <= tgt_x_q;
				prev_y_q <= tgt_y_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_x_q <= in_data.target_x;
			tgt_y_q <= in_data.target_y;
			dx_q    <= $signed({in_data.target_x[31], in_data.target_x})
				- $signed({prev_x_q[31], prev_x_q});
			dy_q    <= $signed({in_data.target_y[31], in_data.target_y})
				- $signed({prev_y_q[31], prev_y_q});
		end
		if (cmd.fin) begin
			case (cmd.op)
				OP_SQX: begin
					dsq_q   <= prod[SQ_W-1:0];
					pitch_q <= sel_pitch;
				end
				OP_SQY: begin
					dsq_q <= dsq_q + prod[SQ_W-1:0];
					lo_q  <= '0;
					hi_q  <= N_NONE;
				end
				OP_SRCH: begin
					if (prod >= PROD_W'(dsq_q))
						hi_q <= mid;
					else
						lo_q <= mid + 1'b1;
				end
				OP_DIVX: begin
					qdx_q <= qd_adj;
					rdx_q <= rd_adj;
				end
				OP_DIVY: begin
					qdy_q  <= qd_adj;
					rdy_q  <= rd_adj;
					i_q    <= '0;
					rx_q   <= '0;
					ry_q   <= '0;
					pt_x_q <= prev_x_q;
					pt_y_q <= prev_y_q;
				end
				OP_CELLX, OP_CELLY: begin
					rloc_q <= (div_neg && ra_nz) ? cur_pitch - div_rem : div_rem;
					if (cval < -36'sd32768) begin
						if (cmd.op == OP_CELLX) begin
							cx_q <= 16'h8000; fx_q <= '0; clx_q <= 1'b1;
						end else begin
							cy_q <= 16'h8000; fy_q <= '0; cly_q <= 1'b1;
						end
					end else if (cval > 36'sd32767) begin
						if (cmd.op == OP_CELLX) begin
							cx_q <= 16'h7fff; fx_q <= 16'hffff; clx_q <= 1'b1;
						end else begin
							cy_q <= 16'h7fff; fy_q <= 16'hffff; cly_q <= 1'b1;
						end
					end else begin
						if (cmd.op == OP_CELLX) begin
							cx_q <= cval[15:0]; clx_q <= 1'b0;
						end else begin
							cy_q <= cval[15:0]; cly_q <= 1'b0;
						end
					end
				end
				OP_FRACX: fx_q <= frac16;
				OP_FRACY: fy_q <= frac16;
				default: ;
			endcase
		end
		// advance to the next subsegment end
		if (cmd.step) begin
			i_q    <= i_q + 1'b1;
			rx_q   <= cyx ? N_W'(rsx - {1'b0, n_val}) : rsx[N_W-1:0];
			ry_q   <= cyy ? N_W'(rsy - {1'b0, n_val}) : rsy[N_W-1:0];
			pt_x_q <= pt_x_q + qdx_q + 32'(cyx);
			pt_y_q <= pt_y_q + qdy_q + 32'(cyy);
		end
		if (cmd.emit) begin
			out_q.point_x     <= pt_x_q;
			out_q.point_y     <= pt_y_q;
			out_q.cell_col    <= cx_q;
			out_q.cell_row    <= cy_q;
			out_q.frac_x      <= fx_q;
			out_q.frac_y      <= fy_q;
			out_q.saturated   <= sat;
			out_q.last_of_run <= (i_q == n_val);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_comb begin
		sts.mul_busy = mul_busy;
		sts.div_busy = div_busy;
		sts.mul_done = mul_done;
		sts.div_done = div_done;
		sts.srch_end = (lo_q == hi_q);
		sts.n_zero   = (n_val == '0);
		sts.last     = (i_q == n_val);
		sts.clamp_x  = clx_q;
		sts.clamp_y  = cly_q;
		sts.out_full = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

[hdl/ssg_ctrl.sv]
module ssg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          func,
	output logic          in_stall,
	input  ssg_pkg::sts_t sts,
	output ssg_pkg::cmd_t cmd
);
	import ssg_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_SQX_GO  = 5'd1;
	localparam logic [4:0] S_SQX_W   = 5'd2;
	localparam logic [4:0] S_SQY_GO  = 5'd3;
	localparam logic [4:0] S_SQY_W   = 5'd4;
	localparam logic [4:0] S_SRCH_GO = 5'd5;
	localparam logic [4:0] S_SRCH_W  = 5'd6;
	localparam logic [4:0] S_DIVX_GO = 5'd7;
	localparam logic [4:0] S_DIVX_W  = 5'd8;
	localparam logic [4:0] S_DIVY_GO = 5'd9;
	localparam logic [4:0] S_DIVY_W  = 5'd10;
	localparam logic [4:0] S_STEP    = 5'd11;
	localparam logic [4:0] S_CX_GO   = 5'd12;
	localparam logic [4:0] S_CX_W    = 5'd13;
	localparam logic [4:0] S_FX_GO   = 5'd14;
	localparam logic [4:0] S_FX_W    = 5'd15;
	localparam logic [4:0] S_CY_GO   = 5'd16;
	localparam logic [4:0] S_CY_W    = 5'd17;
	localparam logic [4:0] S_FY_GO   = 5'd18;
	localparam logic [4:0] S_FY_W    = 5'd19;
	localparam logic [4:0] S_EMIT    = 5'd20;

	logic [4:0] state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	// sequencing of one item
	always_comb begin
		cmd       = '0;
		cmd.op    = OP_NONE;
		state_nxt = state_q;
		in_stall  = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (func)
						state_nxt = S_SQX_GO;
				end
			end
			S_SQX_GO: begin
				cmd.op = OP_SQX; cmd.go = 1'b1; state_nxt = S_SQX_W;
			end
			S_SQX_W: begin
				cmd.op = OP_SQX;
				if (sts.mul_done) begin
					cmd.fin = 1'b1; state_nxt = S_SQY_GO;
				end
			end
			S_SQY_GO: begin
				cmd.op = OP_SQY; cmd.go = 1'b1; state_nxt = S_SQY_W;
			end
			S_SQY_W: begin
				cmd.op = OP_SQY;
				if (sts.mul_done) begin
					cmd.fin = 1'b1; state_nxt = S_SRCH_GO;
				end
			end
			S_SRCH_GO: begin
				if (sts.srch_end) begin
					if (sts.n_zero) begin
						cmd.finish = 1'b1; state_nxt = S_IDLE;
					end else begin
						state_nxt = S_DIVX_GO;
					end
				end else begin
					cmd.op = OP_SRCH; cmd.go = 1'b1; state_nxt = S_SRCH_W;
				end
			end
			S_SRCH_W: begin
				cmd.op = OP_SRCH;
				if (sts.mul_done) begin
					cmd.fin = 1'b1; state_nxt = S_SRCH_GO;
				end
			end
			S_DIVX_GO: begin
				cmd.op = OP_DIVX; cmd.go = 1'b1; state_nxt = S_DIVX_W;
			end
			S_DIVX_W: begin
				cmd.op = OP_DIVX;
				if (sts.div_done) begin
					cmd.fin = 1'b1; state_nxt = S_DIVY_GO;
				end
			end
			S_DIVY_GO: begin
				cmd.op = OP_DIVY; cmd.go = 1'b1; state_nxt = S_DIVY_W;
			end
			S_DIVY_W: begin
				cmd.op = OP_DIVY;
				if (sts.div_done) begin
					cmd.fin = 1'b1; state_nxt = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1; state_nxt = S_CX_GO;
			end
			S_CX_GO: begin
				cmd.op = OP_CELLX; cmd.go = 1'b1; state_nxt = S_CX_W;
			end
			S_CX_W: begin
				cmd.op = OP_CELLX;
				if (sts.div_done) begin
					cmd.fin = 1'b1; state_nxt = S_FX_GO;
				end
			end
			S_FX_GO: begin
				if (sts.clamp_x) begin
					state_nxt = S_CY_GO;
				end else begin
					cmd.op = OP_FRACX; cmd.go = 1'b1; state_nxt = S_FX_W;
				end
			end
			S_FX_W: begin
				cmd.op = OP_FRACX;
				if (sts.div_done) begin
					cmd.fin = 1'b1; state_nxt = S_CY_GO;
				end
			end
			S_CY_GO: begin
				cmd.op = OP_CELLY; cmd.go = 1'b1; state_nxt = S_CY_W;
			end
			S_CY_W: begin
				cmd.op = OP_CELLY;
				if (sts.div_done) begin
					cmd.fin = 1'b1; state_nxt = S_FY_GO;
				end
			end
			S_FY_GO: begin
				if (sts.clamp_y) begin
					state_nxt = S_EMIT;
				end else begin
					cmd.op = OP_FRACY; cmd.go = 1'b1; state_nxt = S_FY_W;
				end
			end
			S_FY_W: begin
				cmd.op = OP_FRACY;
				if (sts.div_done) begin
					cmd.fin = 1'b1; state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!sts.out_full) begin
					cmd.emit = 1'b1;
					if (sts.last) begin
						cmd.finish = 1'b1; state_nxt = S_IDLE;
					end else begin
						state_nxt = S_STEP;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end
endmodule

[hdl/segment_split_grid_locate.sv]
// Splits a tool-path move into up to MAX_SUBSEGMENTS equal subsegments and
// gives for each end point its probe-grid cell and the Q0.16 position inside
// the cell. A jump word is taken without leaving the idle state. A chain word
// is worked on alone: two squarings, a binary search for the count of at most
// seven further squarings, two divisions, then per subsegment two cell
// divisions and two FRAC_BITS-bit fraction divisions, all on one shared
// shift-add multiplier and one shared restoring divider. A fraction division
// is skipped where a cell is clamped off the grid, and the work waits in the
// emit state while the output register is full. The next input word is taken
// while the last result still waits in the output register.
module segment_split_grid_locate #(
	parameter int MAX_SUBSEGMENTS = ssg_pkg::MAX_SUB_DEF,
	parameter int FRAC_BITS       = ssg_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ssg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssg_pkg::CFG_W-1:0]     cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  ssg_pkg::in_word_t             in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output ssg_pkg::out_word_t            out_data
);
	import ssg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ssg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (in_data.func),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	ssg_dp #(
		.MAX_SUBSEGMENTS(MAX_SUBSEGMENTS),
		.FRAC_BITS      (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// the two shared units never run together
	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.mul_busy && sts.div_busy))
		else $error("multiplier and divider busy together");

	// a word is only taken with both units idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (!sts.mul_busy && !sts.div_busy))
		else $error("input taken while arithmetic busy");

	// a result never overwrites one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_full)
		else $error("output register overwritten");

	// a result step follows only a finished search
	a_step_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (sts.srch_end && !sts.n_zero))
		else $error("subsegment step without a count");
endmodule
